[rtl/cnm_pkg.sv]
`default_nettype none
package cnm_pkg;
   localparam int unsigned NumSourcesDefault = 1024;
   localparam int unsigned TimeWidth = 48;
   localparam int unsigned CntWidth = 16;
   localparam int unsigned RateWidth = 13;
   localparam logic [CntWidth-1:0] CntMax = 16'hFFFF;
   localparam logic [RateWidth-1:0] RateMax = 13'h1FFF;
   localparam logic [1:0] MarkCongested = 2'd1;
   localparam logic [1:0] MarkClear = 2'd3;
   localparam logic [1:0] FecnSet = 2'd1;
   localparam logic NoticeBecn = 1'b0;
   localparam logic NoticeFecn = 1'b1;

   typedef enum logic [1:0] {
      CSR_LEGACY = 2'd0,
      CSR_WINDOW = 2'd1,
      CSR_WIN_NS = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      BE_IDLE,
      BE_READ,
      BE_CALC,
      BE_DIV,
      BE_EMIT1,
      BE_EMIT2
   } be_state_type;

   // classified word passed from front to back
   typedef struct packed {
      logic        fwd;       // BECN forward
      logic        count;     // source in range, counted
      logic        fecn_only;
      logic        legacy;
      logic        window;
      logic [15:0] win_ns;
      logic [9:0]  src_id;
      logic [9:0]  dst_id;
      logic [3:0]  service_level;
      logic [7:0]  app_index;
      logic [15:0] msg_index;
      logic [12:0] carried_rate;
      logic        becn_flag;
      logic [47:0] arrival_ns;
   } item_type;
endpackage
`default_nettype wire

[rtl/cnm_front.sv]
`default_nettype none
module cnm_front #(
   parameter int unsigned NUM_SOURCES = cnm_pkg::NumSourcesDefault
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [9:0]        req_src_id,
   input  wire logic [9:0]        req_dst_id,
   input  wire logic [1:0]        req_fecn_mark,
   input  wire logic              req_becn_flag,
   input  wire logic [3:0]        req_service_level,
   input  wire logic [7:0]        req_app_index,
   input  wire logic [15:0]       req_msg_index,
   input  wire logic [12:0]       req_carried_rate,
   input  wire logic [47:0]       req_arrival_ns,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [15:0]       csr_wdata,
   output logic                   q_push,
   output cnm_pkg::item_type      q_item,
   input  wire logic              q_full
);
   logic legacy_ff, window_ff;
   logic [15:0] win_ns_ff;
   logic any;

   assign csr_ready = 1'b1;
   assign busy = q_full;
   assign any = legacy_ff | window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         legacy_ff <= 1'b0;
         window_ff <= 1'b0;
         win_ns_ff <= 16'd8192;
      end else if (csr_valid) begin
         case (cnm_pkg::csr_index_type'(csr_index))
            cnm_pkg::CSR_LEGACY: legacy_ff <= csr_wdata[0];
            cnm_pkg::CSR_WINDOW: window_ff <= csr_wdata[0];
            cnm_pkg::CSR_WIN_NS: win_ns_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      q_item.fwd = req_becn_flag && (req_fecn_mark == 2'd0);
      q_item.count = !q_item.fwd && ({22'd0, req_src_id} < NUM_SOURCES);
      q_item.fecn_only = (req_fecn_mark == cnm_pkg::FecnSet) && !req_becn_flag;
      q_item.legacy = legacy_ff;
      q_item.window = window_ff;
      q_item.win_ns = win_ns_ff;
      q_item.src_id = req_src_id;
      q_item.dst_id = req_dst_id;
      q_item.service_level = req_service_level;
      q_item.app_index = req_app_index;
      q_item.msg_index = req_msg_index;
      q_item.carried_rate = req_carried_rate;
      q_item.becn_flag = req_becn_flag;
      q_item.arrival_ns = req_arrival_ns;
   end

   // flits with both schemes off are dropped here
   assign q_push = start && !q_full && any;
endmodule
`default_nettype wire

[rtl/cnm_queue.sv]
`default_nettype none
module cnm_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire cnm_pkg::item_type wr_item,
   output logic                   full,
   input  wire logic              pop,
   output logic                   not_empty,
   output cnm_pkg::item_type      rd_item
);
   cnm_pkg::item_type mem_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic wp_ff, rp_ff;

   assign full = cnt_ff[1];
   assign not_empty = cnt_ff != 2'd0;
   assign rd_item = mem_ff[rp_ff];
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= wr_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
      end
   end

   assert property (@(posedge clock) disable iff (reset) full |-> !push)
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset) !not_empty |-> !pop)
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count overflow");
endmodule
`default_nettype wire

[rtl/cnm_div.sv]
`default_nettype none
// radix-2 restoring divider: 38-bit dividend by 48-bit divisor, 38-bit quotient
module cnm_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        go,
   input  wire logic [37:0] dividend,
   input  wire logic [47:0] divisor,
   output logic             done,
   output logic [37:0]      quotient
);
   logic [48:0] rem_ff, rem_in;
   logic [37:0] q_ff;
   logic [47:0] d_ff;
   logic [5:0]  step_ff;
   logic        run_ff;
   logic [48:0] trial;

   assign rem_in = {rem_ff[47:0], q_ff[37]};
   assign trial = rem_in - {1'b0, d_ff};
   assign quotient = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done <= 1'b0;
         step_ff <= 6'd0;
      end else begin
         done <= 1'b0;
         if (go) begin
            run_ff <= 1'b1;
            step_ff <= 6'd0;
         end else if (run_ff) begin
            step_ff <= step_ff + 6'd1;
            if (step_ff == 6'd37) begin
               run_ff <= 1'b0;
               done <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         rem_ff <= 49'd0;
         q_ff <= dividend;
         d_ff <= divisor;
      end else if (run_ff) begin
         if (!trial[48]) begin
            rem_ff <= trial;
            q_ff <= {q_ff[36:0], 1'b1};
         end else begin
            rem_ff <= rem_in;
            q_ff <= {q_ff[36:0], 1'b0};
         end
      end
   end
endmodule
`default_nettype wire

[rtl/cnm_back.sv]
`default_nettype none
module cnm_back #(
   parameter int unsigned NUM_SOURCES = cnm_pkg::NumSourcesDefault
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire cnm_pkg::item_type q_item,
   output logic                   q_pop,
   output logic                   rsp_valid,
   output logic                   rsp_notice_kind,
   output logic [9:0]             rsp_out_src_id,
   output logic [9:0]             rsp_out_dst_id,
   output logic [3:0]             rsp_out_service_level,
   output logic [7:0]             rsp_out_app_index,
   output logic [15:0]            rsp_out_msg_index,
   output logic [12:0]            rsp_notice_rate,
   output logic [1:0]             rsp_mark_value,
   output logic                   rsp_last_notice
);
   localparam int unsigned AW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

   cnm_pkg::be_state_type state_ff, state_in;
   cnm_pkg::item_type it_ff;
   logic [15:0] flit_mem [NUM_SOURCES];
   logic [15:0] fecn_mem [NUM_SOURCES];
   logic [47:0] start_mem [NUM_SOURCES];
   logic        vld_mem [NUM_SOURCES];
   logic        clearing_ff;
   logic [AW-1:0] clr_ff;
   logic [15:0] flit_rd_ff, fecn_rd_ff;
   logic [47:0] start_rd_ff;
   logic        vld_rd_ff;
   logic [15:0] flit_ff, fecn_ff;
   logic [47:0] interval_ff;
   logic close_ff, cong_ff;
   logic [12:0] rate_ff;
   logic send_ff, win_n, leg_n;
   logic [AW-1:0] addr;
   logic wr_en;
   logic [15:0] flit_new, fecn_new;
   logic [47:0] start_eff, interval;
   logic close, div_go, div_done;
   logic [37:0] div_q;
   logic [19:0] f10, c9;

   assign addr = AW'(it_ff.src_id);

   // window flags cleared one entry per cycle after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_ff <= '0;
      end else if (clearing_ff) begin
         clr_ff <= clr_ff + AW'(1);
         if (clr_ff == AW'(NUM_SOURCES - 1)) clearing_ff <= 1'b0;
      end
   end

   // read stage
   always_ff @(posedge clock) begin
      if (state_ff == cnm_pkg::BE_READ) begin
         flit_rd_ff <= flit_mem[addr];
         fecn_rd_ff <= fecn_mem[addr];
         start_rd_ff <= start_mem[addr];
         vld_rd_ff <= vld_mem[addr];
      end
   end

   always_comb begin
      logic vld;
      vld = vld_rd_ff;
      flit_new = (vld && flit_rd_ff == cnm_pkg::CntMax) ? flit_rd_ff :
                 (vld ? flit_rd_ff : 16'd0) + 16'd1;
      fecn_new = vld ? fecn_rd_ff : 16'd0;
      if (it_ff.fecn_only && fecn_new != cnm_pkg::CntMax) fecn_new = fecn_new + 16'd1;
      start_eff = vld ? start_rd_ff : it_ff.arrival_ns;
      interval = it_ff.arrival_ns - start_eff;
      close = interval >= {32'd0, it_ff.win_ns};
   end

   assign wr_en = (state_ff == cnm_pkg::BE_CALC) && it_ff.count;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         flit_mem[addr] <= close ? 16'd0 : flit_new;
         fecn_mem[addr] <= close ? 16'd0 : fecn_new;
         start_mem[addr] <= close ? it_ff.arrival_ns : start_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) vld_mem[clr_ff] <= 1'b0;
      else if (wr_en) vld_mem[addr] <= 1'b1;
   end

   always_ff @(posedge clock) begin
      if (q_pop) it_ff <= q_item;
      if (state_ff == cnm_pkg::BE_CALC) begin
         flit_ff <= flit_new;
         fecn_ff <= fecn_new;
         interval_ff <= interval;
         close_ff <= close && it_ff.count;
      end
   end

   assign f10 = {1'b0, fecn_ff, 3'd0} + {3'd0, fecn_ff, 1'b0};
   assign c9 = {1'b0, flit_ff, 3'd0} + {4'd0, flit_ff};

   // operands taken straight from the read stage, captured at the end of CALC
   cnm_div u_div (
      .clock(clock), .reset(reset), .go(div_go),
      .dividend({flit_new, 22'd0}), .divisor(interval),
      .done(div_done), .quotient(div_q)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cnm_pkg::BE_IDLE: if (q_pop) state_in = cnm_pkg::BE_READ;
         cnm_pkg::BE_READ: state_in = it_ff.fwd ? cnm_pkg::BE_EMIT2 : cnm_pkg::BE_CALC;
         cnm_pkg::BE_CALC: state_in = cnm_pkg::BE_DIV;
         cnm_pkg::BE_DIV: begin
            if (!(close_ff && f10 > c9 && interval_ff != 48'd0) || div_done)
               state_in = cnm_pkg::BE_EMIT1;
         end
         cnm_pkg::BE_EMIT1: state_in = cnm_pkg::BE_EMIT2;
         cnm_pkg::BE_EMIT2: state_in = cnm_pkg::BE_IDLE;
         default: state_in = cnm_pkg::BE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= cnm_pkg::BE_IDLE;
      else state_ff <= state_in;
   end

   assign q_pop = (state_ff == cnm_pkg::BE_IDLE) && q_valid && !clearing_ff;
   assign div_go = (state_ff == cnm_pkg::BE_CALC);

   // rate and notice selection at divide end
   always_ff @(posedge clock) begin
      if (state_ff == cnm_pkg::BE_DIV && state_in == cnm_pkg::BE_EMIT1) begin
         cong_ff <= f10 > c9;
         if (!close_ff || !(f10 > c9)) begin
            rate_ff <= 13'd0;
            send_ff <= close_ff;
         end else if (interval_ff == 48'd0 || div_q[37:13] != 25'd0) begin
            rate_ff <= cnm_pkg::RateMax;
            send_ff <= 1'b0;
         end else begin
            rate_ff <= div_q[12:0];
            send_ff <= close_ff;
         end
      end
   end

   always_comb begin
      win_n = send_ff && it_ff.window;
      leg_n = it_ff.legacy && it_ff.fecn_only;
   end

   always_comb begin
      rsp_valid = 1'b0;
      rsp_notice_kind = cnm_pkg::NoticeFecn;
      rsp_out_src_id = it_ff.src_id;
      rsp_out_dst_id = it_ff.dst_id;
      rsp_out_service_level = 4'd0;
      rsp_out_app_index = it_ff.app_index;
      rsp_out_msg_index = it_ff.msg_index;
      rsp_notice_rate = rate_ff;
      rsp_mark_value = cong_ff ? cnm_pkg::MarkCongested : cnm_pkg::MarkClear;
      rsp_last_notice = 1'b1;
      case (state_ff)
         cnm_pkg::BE_EMIT1: begin
            rsp_valid = win_n;
            rsp_last_notice = !leg_n;
         end
         cnm_pkg::BE_EMIT2: begin
            if (it_ff.fwd) begin
               rsp_valid = 1'b1;
               rsp_notice_kind = cnm_pkg::NoticeBecn;
               rsp_out_service_level = it_ff.service_level;
               rsp_notice_rate = it_ff.carried_rate;
               rsp_mark_value = {1'b0, it_ff.becn_flag};
            end else begin
               rsp_valid = leg_n;
               rsp_mark_value = cnm_pkg::MarkCongested;
            end
         end
         default: ;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == cnm_pkg::BE_IDLE)
      else $error("pop while busy");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == cnm_pkg::BE_EMIT1 || state_ff == cnm_pkg::BE_EMIT2))
      else $error("notice outside emit");
   assert property (@(posedge clock) disable iff (reset)
      wr_en |=> state_ff == cnm_pkg::BE_DIV)
      else $error("counter write out of order");
   assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !q_pop)
      else $error("pop during clearing pass");
endmodule
`default_nettype wire

[rtl/congestion_notification_monitor_top.sv]
`default_nettype none
// Congestion notification monitor.
// Request: pulse start with one flit word on req_*; it is taken when busy is
// low. Both schemes off: the word is dropped and gives no notice.
// Response: each notice word is on rsp_* for one cycle with rsp_valid high;
// rsp_last_notice marks the final notice of a flit. The receiver cannot stall.
// CSR: csr_valid/csr_ready write, index 0 legacy enable, 1 window enable,
// 2 window length in ns; ready is always high. Write only while idle.
// A two-entry queue parts the front (accept, classify) from the back
// (per-source counters in memory, one read-modify-write per counted flit).
// Path: a BECN forward goes READ then EMIT2; a counted flit goes READ, CALC,
// DIV, then EMIT1 for its window notice and EMIT2 for its legacy notice; DIV
// waits for the 38-step serial divider when the window closes congested.
// Flow: the back end takes a new flit only once the last has left EMIT2;
// dropped flits are taken every cycle while busy is low.
// Reset: registers at defaults; the NUM_SOURCES (1024 by default) per-source
// window flags are cleared one per cycle, and flits wait in the queue until
// that pass ends.
module congestion_notification_monitor_top #(
   parameter int unsigned NUM_SOURCES = cnm_pkg::NumSourcesDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [9:0]  req_src_id,
   input  wire logic [9:0]  req_dst_id,
   input  wire logic [1:0]  req_fecn_mark,
   input  wire logic        req_becn_flag,
   input  wire logic [3:0]  req_service_level,
   input  wire logic [7:0]  req_app_index,
   input  wire logic [15:0] req_msg_index,
   input  wire logic [12:0] req_carried_rate,
   input  wire logic [47:0] req_arrival_ns,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   output logic             rsp_valid,
   output logic             rsp_notice_kind,
   output logic [9:0]       rsp_out_src_id,
   output logic [9:0]       rsp_out_dst_id,
   output logic [3:0]       rsp_out_service_level,
   output logic [7:0]       rsp_out_app_index,
   output logic [15:0]      rsp_out_msg_index,
   output logic [12:0]      rsp_notice_rate,
   output logic [1:0]       rsp_mark_value,
   output logic             rsp_last_notice
);
   cnm_pkg::item_type push_item, pop_item;
   logic push, full, pop, not_empty;

   cnm_front #(.NUM_SOURCES(NUM_SOURCES)) u_front (
      .clock, .reset, .start, .busy,
      .req_src_id, .req_dst_id, .req_fecn_mark, .req_becn_flag,
      .req_service_level, .req_app_index, .req_msg_index,
      .req_carried_rate, .req_arrival_ns,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .q_push(push), .q_item(push_item), .q_full(full)
   );

   cnm_queue u_queue (
      .clock, .reset, .push, .wr_item(push_item), .full,
      .pop, .not_empty, .rd_item(pop_item)
   );

   cnm_back #(.NUM_SOURCES(NUM_SOURCES)) u_back (
      .clock, .reset, .q_valid(not_empty), .q_item(pop_item), .q_pop(pop),
      .rsp_valid, .rsp_notice_kind, .rsp_out_src_id, .rsp_out_dst_id,
      .rsp_out_service_level, .rsp_out_app_index, .rsp_out_msg_index,
      .rsp_notice_rate, .rsp_mark_value, .rsp_last_notice
   );
endmodule
`default_nettype wire
